[hdl/hsfb_pkg.sv]
// Shared types, codes and helpers of the HDLC-style frame builder.
package hsfb_pkg;

  localparam int HSFB_QDEPTH = 4;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_CMD_ADDR  = 3'd0,
    REG_RSP_ADDR  = 3'd1,
    REG_FLAG      = 3'd2,
    REG_ESC       = 3'd3,
    REG_ESC_FLAG  = 3'd4,
    REG_ESC_ESC   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] cmd_addr;
    logic [7:0] rsp_addr;
    logic [7:0] flag;
    logic [7:0] esc;
    logic [7:0] flag_code;
    logic [7:0] esc_esc;
  } cfg_t;

  // one queued job: up to four line bytes, sent from index 0 up
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            fend;
  } job_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
  } stuffed_t;

  function automatic stuffed_t stuff(input logic [7:0] b, input cfg_t c);
    stuffed_t s;
    s.b0  = b;
    s.b1  = 8'h00;
    s.two = 1'b0;
    if (b == c.flag) begin
      s.b0  = c.esc;
      s.b1  = c.flag_code;
      s.two = 1'b1;
    end else if (b == c.esc) begin
      s.b0  = c.esc;
      s.b1  = c.esc_esc;
      s.two = 1'b1;
    end
    return s;
  endfunction

endpackage

[hdl/hdlc_style_frame_builder_top.sv]
// Top level of the HDLC-style frame builder with byte stuffing.
// Line bytes pass through the job queue, the current-job register and the output register.
// Throughput: one line byte per cycle while out_tready is high; a word produces 1 to 4
// line bytes, sent one at a time by the single-byte output serializer in the back end.
// Ignored words are accepted and produce nothing.
// Reset (rst_n low, synchronous) closes any frame, empties the queue, restores registers.
module hdlc_style_frame_builder_top #(
  parameter int QDEPTH = hsfb_pkg::HSFB_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] control_byte, [15:8] payload_byte
  input  logic [2:0]  in_tuser,   // [1:0] mode, [2] use_response_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] line_byte
  output logic        out_tlast,  // run_last
  output logic        out_tuser,  // [0] frame_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hsfb_pkg::*;

  cfg_t cfg;
  job_t push_job, pop_job;
  logic q_push, q_full, q_pop, q_vld;

  hsfb_regs u_regs (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .cfg
  );

  hsfb_front u_front (
    .clk, .rst_n, .cfg,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_full, .q_push, .q_job(push_job)
  );

  hsfb_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst_n,
    .push(q_push), .wr_job(push_job), .full(q_full),
    .pop(q_pop), .rd_job(pop_job), .not_empty(q_vld)
  );

  hsfb_back u_back (
    .clk, .rst_n,
    .q_vld, .q_job(pop_job), .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

endmodule

[hdl/hsfb_regs.sv]
// APB configuration registers of the frame builder.
module hsfb_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output hsfb_pkg::cfg_t    cfg
);
  import hsfb_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;
  logic [7:0] rd_byte;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_addr  <= 8'd3;
      cfg_r.rsp_addr  <= 8'd1;
      cfg_r.flag      <= 8'd126;
      cfg_r.esc       <= 8'd125;
      cfg_r.flag_code <= 8'd94;
      cfg_r.esc_esc   <= 8'd93;
    end else if (wr) begin
      case (idx)
        REG_CMD_ADDR: cfg_r.cmd_addr  <= cfg_pwdata[7:0];
        REG_RSP_ADDR: cfg_r.rsp_addr  <= cfg_pwdata[7:0];
        REG_FLAG:     cfg_r.flag      <= cfg_pwdata[7:0];
        REG_ESC:      cfg_r.esc       <= cfg_pwdata[7:0];
        REG_ESC_FLAG: cfg_r.flag_code <= cfg_pwdata[7:0];
        REG_ESC_ESC:  cfg_r.esc_esc   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CMD_ADDR: rd_byte = cfg_r.cmd_addr;
      REG_RSP_ADDR: rd_byte = cfg_r.rsp_addr;
      REG_FLAG:     rd_byte = cfg_r.flag;
      REG_ESC:      rd_byte = cfg_r.esc;
      REG_ESC_FLAG: rd_byte = cfg_r.flag_code;
      REG_ESC_ESC:  rd_byte = cfg_r.esc_esc;
      default:      rd_byte = 8'h00;
    endcase
  end

  assign cfg_prdata = {24'h000000, rd_byte};

endmodule

[hdl/hsfb_front.sv]
// Front end: accepts words, tracks frame state and builds byte jobs.
module hsfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  hsfb_pkg::cfg_t    cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output hsfb_pkg::job_t    q_job
);
  import hsfb_pkg::*;

  logic       open_r, open_nxt;
  logic       seen_r, seen_nxt;
  logic [7:0] par_r, par_nxt;

  mode_t      mode;
  logic [7:0] ctrl, data, addr;
  logic       acc, emit;
  stuffed_t   s_data, s_par;

  assign mode = mode_t'(in_tuser[1:0]);
  assign ctrl = in_tdata[7:0];
  assign data = in_tdata[15:8];
  assign addr = in_tuser[2] ? cfg.rsp_addr : cfg.cmd_addr;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign s_data    = stuff(data, cfg);
  assign s_par     = stuff(par_r, cfg);

  always_comb begin
    open_nxt   = open_r;
    seen_nxt   = seen_r;
    par_nxt    = par_r;
    emit       = 1'b0;
    q_job      = '0;
    case (mode)
      MODE_OPEN: begin
        emit        = 1'b1;
        q_job.bytes = {addr ^ ctrl, ctrl, addr, cfg.flag};
        q_job.cnt   = 3'd4;
        open_nxt    = 1'b1;
        seen_nxt    = 1'b0;
        par_nxt     = 8'h00;
      end
      MODE_DATA: begin
        if (open_r) begin
          emit        = 1'b1;
          q_job.bytes = {16'h0000, s_data.b1, s_data.b0};
          q_job.cnt   = s_data.two ? 3'd2 : 3'd1;
          seen_nxt    = 1'b1;
          par_nxt     = par_r ^ data;
        end
      end
      MODE_CLOSE: begin
        if (open_r) begin
          emit       = 1'b1;
          q_job.fend = 1'b1;
          if (!seen_r) begin
            q_job.bytes = {24'h000000, cfg.flag};
            q_job.cnt   = 3'd1;
          end else if (s_par.two) begin
            q_job.bytes = {8'h00, cfg.flag, s_par.b1, s_par.b0};
            q_job.cnt   = 3'd3;
          end else begin
            q_job.bytes = {16'h0000, cfg.flag, s_par.b0};
            q_job.cnt   = 3'd2;
          end
          open_nxt = 1'b0;
          seen_nxt = 1'b0;
          par_nxt  = 8'h00;
        end
      end
      default: ;
    endcase
  end

  assign q_push = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      seen_r <= 1'b0;
      par_r  <= 8'h00;
    end else if (acc) begin
      open_r <= open_nxt;
      seen_r <= seen_nxt;
      par_r  <= par_nxt;
    end
  end

endmodule

[hdl/hsfb_fifo.sv]
// Small job queue between front and back end.
module hsfb_fifo #(
  parameter int DEPTH = hsfb_pkg::HSFB_QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hsfb_pkg::job_t    wr_job,
  output logic              full,
  input  logic              pop,
  output hsfb_pkg::job_t    rd_job,
  output logic              not_empty
);
  import hsfb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full      = (cnt_r == FULLC);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_job    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[hdl/hsfb_back.sv]
// Back end: serializes queued jobs into one line byte per cycle when out_tready does not stall it.
module hsfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  input  hsfb_pkg::job_t    q_job,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import hsfb_pkg::*;

  job_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic       out_last_r, out_fend_r;
  logic       adv, last_byte;

  assign adv       = cur_vld_r && (!out_vld_r || out_tready);
  assign last_byte = ({1'b0, idx_r} == (cur_r.cnt - 3'd1));
  assign q_pop     = q_vld && (!cur_vld_r || (adv && last_byte));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 2'd0;
      end else if (adv) begin
        if (last_byte) cur_vld_r <= 1'b0;
        else           idx_r     <= idx_r + 2'd1;
      end
      if (adv)             out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
    if (adv) begin
      out_byte_r <= cur_r.bytes[idx_r];
      out_last_r <= last_byte;
      out_fend_r <= last_byte && cur_r.fend;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_fend_r;

endmodule

[hdl/hsfb_checker.sv]
// Port-level checks of the frame builder and their binding.
module hsfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("closing flag not marked as last of its run");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind hdlc_style_frame_builder_top hsfb_checker u_hsfb_checker (.*);

[dv/tb_hdlc_style_frame_builder_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the HDLC-style frame builder: table-driven and random frames.
module tb_hdlc_style_frame_builder_top;
  import hsfb_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int WORDS_PER_PHASE = 50;
  localparam int N_DIR = 25;

  typedef struct packed {
    logic [7:0] b;
    logic       run_last;
    logic       frame_last;
  } line_byte_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [7:0]      ctrl;
    logic            resp;
    logic [7:0]      pay;
    logic            typed;
    logic [2:0]      n_want;
    logic [0:3][7:0] want;
    logic            fend;
  } dir_row_t;

  // reset register values; typed rows hold the bytes in line order
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{MODE_CLOSE,  8'h00, 1'b0, 8'h00, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_DATA,   8'hFF, 1'b1, 8'hFF, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_UNUSED, 8'hFF, 1'b1, 8'hFF, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_OPEN,   8'h00, 1'b0, 8'h00, 1'b1, 3'd4, 32'h7E03_0003, 1'b0},
    '{MODE_CLOSE,  8'h00, 1'b0, 8'h00, 1'b1, 3'd1, 32'h7E00_0000, 1'b1},
    '{MODE_OPEN,   8'hFF, 1'b1, 8'h00, 1'b1, 3'd4, 32'h7E01_FFFE, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h7E, 1'b1, 3'd2, 32'h7D5E_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h7D, 1'b1, 3'd2, 32'h7D5D_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h00, 1'b1, 3'd1, 32'h0000_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'hFF, 1'b1, 3'd1, 32'hFF00_0000, 1'b0},
    '{MODE_UNUSED, 8'h00, 1'b0, 8'h00, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_CLOSE,  8'h00, 1'b0, 8'h00, 1'b1, 3'd2, 32'hFC7E_0000, 1'b1},
    '{MODE_OPEN,   8'h7E, 1'b0, 8'h00, 1'b1, 3'd4, 32'h7E03_7E7D, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h7E, 1'b1, 3'd2, 32'h7D5E_0000, 1'b0},
    '{MODE_CLOSE,  8'h00, 1'b0, 8'h00, 1'b1, 3'd3, 32'h7D5E_7E00, 1'b1},
    '{MODE_OPEN,   8'h7D, 1'b1, 8'h00, 1'b1, 3'd4, 32'h7E01_7D7C, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h7D, 1'b1, 3'd2, 32'h7D5D_0000, 1'b0},
    '{MODE_CLOSE,  8'h00, 1'b0, 8'h00, 1'b1, 3'd3, 32'h7D5D_7E00, 1'b1},
    '{MODE_OPEN,   8'h55, 1'b1, 8'h00, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h7D, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_OPEN,   8'hAA, 1'b0, 8'h00, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h12, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h81, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_CLOSE,  8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{MODE_DATA,   8'h00, 1'b0, 8'h34, 1'b0, 3'd0, 32'h0000_0000, 1'b0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] control_byte, [15:8] payload_byte
  logic [2:0]  in_tuser = '0;   // [1:0] mode, [2] use_response_address
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] line_byte
  logic        out_tlast;
  logic        out_tuser;       // [0] frame_last
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hdlc_style_frame_builder_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // framer model state
  cfg_t       regs_m = 48'h03_01_7E_7D_5E_5D;
  logic       frame_open_m = 1'b0;
  logic       payload_seen_m = 1'b0;
  logic [7:0] bcc2_m = 8'h00;

  line_byte_t step_bytes[$];
  line_byte_t line_bytes_due[$];
  line_byte_t got_due;
  int         mismatches = 0;
  int         words_done = 0;
  int         quiet = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t mismatch %s: got %02h want %02h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic emit(input logic [7:0] b, input logic last, input logic fend);
    step_bytes.push_back('{b: b, run_last: last, frame_last: fend});
  endtask

  task automatic emit_stuffed(input logic [7:0] b, input logic last);
    if (b == regs_m.flag) begin
      emit(regs_m.esc, 1'b0, 1'b0);
      emit(regs_m.flag_code, last, 1'b0);
    end else if (b == regs_m.esc) begin
      emit(regs_m.esc, 1'b0, 1'b0);
      emit(regs_m.esc_esc, last, 1'b0);
    end else begin
      emit(b, last, 1'b0);
    end
  endtask

  // line bytes caused by one input word
  task automatic frame_step(input logic [1:0] mode, input logic [7:0] ctrl, input logic resp,
                            input logic [7:0] pay);
    logic [7:0] addr;
    step_bytes.delete();
    case (mode)
      MODE_OPEN: begin
        addr = resp ? regs_m.rsp_addr : regs_m.cmd_addr;
        emit(regs_m.flag, 1'b0, 1'b0);
        emit(addr, 1'b0, 1'b0);
        emit(ctrl, 1'b0, 1'b0);
        emit(addr ^ ctrl, 1'b1, 1'b0);
        frame_open_m = 1'b1;
        payload_seen_m = 1'b0;
        bcc2_m = 8'h00;
      end
      MODE_DATA: if (frame_open_m) begin
        bcc2_m = bcc2_m ^ pay;
        payload_seen_m = 1'b1;
        emit_stuffed(pay, 1'b1);
      end
      MODE_CLOSE: if (frame_open_m) begin
        if (payload_seen_m) emit_stuffed(bcc2_m, 1'b0);
        emit(regs_m.flag, 1'b1, 1'b1);
        frame_open_m = 1'b0;
        payload_seen_m = 1'b0;
        bcc2_m = 8'h00;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [1:0] mode, input logic [7:0] ctrl, input logic resp,
                           input logic [7:0] pay, input bit typed);
    int gap;
    if ($urandom_range(0, 31) == 0) in_calm = ~in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pay, ctrl};
    in_tuser <= {resp, mode};
    do @(posedge clk); while (!in_tready);
    frame_step(mode, ctrl, resp, pay);
    if (step_bytes.size() > 0) words_done++;
    if (!typed) begin
      foreach (step_bytes[k]) line_bytes_due.push_back(step_bytes[k]);
    end
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [7:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'h0, v}) note_mismatch("register readback", cfg_prdata[7:0], v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CMD_ADDR: regs_m.cmd_addr = v;
      REG_RSP_ADDR: regs_m.rsp_addr = v;
      REG_FLAG:     regs_m.flag = v;
      REG_ESC:      regs_m.esc = v;
      REG_ESC_FLAG: regs_m.flag_code = v;
      REG_ESC_ESC:  regs_m.esc_esc = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (line_bytes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return regs_m.flag;
      1: return regs_m.esc;
      2: return regs_m.flag_code;
      3: return regs_m.esc_esc;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed frames; some stray, unused-mode and abandoned words
  task automatic random_frame();
    int n;
    logic [7:0] p;
    if ($urandom_range(0, 7) == 0) begin
      send_word(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 1'b0);
    end else begin
      send_word(MODE_OPEN, pick_byte(), 1'($urandom), 8'($urandom), 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0)
          send_word(MODE_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0);
        // steer the check byte onto flag or escape now and then
        if ($urandom_range(0, 5) == 0)
          p = bcc2_m ^ ($urandom_range(0, 1) ? regs_m.flag : regs_m.esc);
        else
          p = pick_byte();
        send_word(MODE_DATA, 8'($urandom), 1'($urandom), p, 1'b0);
      end
      if ($urandom_range(0, 9) != 0)
        send_word(MODE_CLOSE, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = ~out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (line_bytes_due.size() == 0) begin
        note_mismatch("unexpected line byte", out_tdata, 8'h00);
      end else begin
        got_due = line_bytes_due.pop_front();
        if (out_tdata !== got_due.b) note_mismatch("line_byte", out_tdata, got_due.b);
        if (out_tlast !== got_due.run_last)
          note_mismatch("run_last", {7'h0, out_tlast}, {7'h0, got_due.run_last});
        if (out_tuser !== got_due.frame_last)
          note_mismatch("frame_last", {7'h0, out_tuser}, {7'h0, got_due.frame_last});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    dir_row_t r;
    cfg_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      r = DIR_ROWS[i];
      send_word(r.mode, r.ctrl, r.resp, r.pay, r.typed);
      if (r.typed) begin
        for (int k = 0; k < r.n_want; k++)
          line_bytes_due.push_back('{b: r.want[k], run_last: (k == r.n_want - 1),
                                     frame_last: r.fend && (k == r.n_want - 1)});
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: c = 48'h00_00_00_00_00_00;
        1: c = 48'hFF_FF_FF_FF_FF_FF;
        2: begin
          c = cfg_t'({$urandom, 16'($urandom)});
          c.esc = c.flag;
        end
        3: c = 48'hFF_00_00_FF_FF_00;
        4: c = cfg_t'({$urandom, 16'($urandom)});
        default: c = 48'h03_01_7E_7D_5E_5D;
      endcase
      cfg_write(REG_CMD_ADDR, c.cmd_addr);
      cfg_write(REG_RSP_ADDR, c.rsp_addr);
      cfg_write(REG_FLAG, c.flag);
      cfg_write(REG_ESC, c.esc);
      cfg_write(REG_ESC_FLAG, c.flag_code);
      cfg_write(REG_ESC_ESC, c.esc_esc);
      words_done = 0;
      while (words_done < WORDS_PER_PHASE) random_frame();
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
